// ===== rtl/wlcg_pkg.sv =====
// Package for the windowed linear chirp generator.
// Holds defaults, register indexes, shared types and the quarter-wave sine entry function.
// Depends on nothing.
package wlcg_pkg;

   localparam int PhaseBitsDef     = 32;
   localparam int TableAddrBitsDef = 10;
   localparam int SampleBitsDef    = 16;

   localparam int CfgAddrBits = 5;
   localparam int CfgDataBits = 32;

   typedef enum logic [2:0] {
      REG_FIRST_STEP    = 3'd0,
      REG_STEP_GROWTH   = 3'd1,
      REG_WINDOW_STEP   = 3'd2,
      REG_CHIRP_LENGTH  = 3'd3,
      REG_CHIRP_REPEATS = 3'd4,
      REG_WINDOW_ON     = 3'd5,
      REG_OUTPUT_SINE   = 3'd6
   } reg_index_type;

   localparam logic [15:0] ChirpLengthRst  = 16'd1024;
   localparam logic [15:0] ChirpRepeatsRst = 16'd1;
   localparam logic        WindowOnRst     = 1'b1;
   localparam logic        OutputSineRst   = 1'b0;

   localparam longint unsigned PiHalfQ30 = 64'd1686629713;
   localparam longint unsigned TaylorDiv [10] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   // control flags that travel with a sample down the pipeline
   typedef struct packed {
      logic chirp_end;
      logic burst_end;
      logic idle;
      logic window_on;
   } flags_type;

   // entry k of the quarter-wave table: sin(pi/2 * k / 2^addr_bits) scaled to full scale
   function automatic longint unsigned sine_entry(int unsigned k, int unsigned addr_bits,
                                                  int unsigned sample_bits);
      longint unsigned x;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned v;
      longint unsigned amp;
      int unsigned     n;
      amp  = (64'd1 << (sample_bits - 1)) - 64'd1;
      x    = (PiHalfQ30 * 64'(k)) >> addr_bits;
      sum  = x;
      term = x;
      for (n = 1; n <= 10; n++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / TaylorDiv[n - 1];
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (amp * sum + (64'd1 << 29)) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

// ===== rtl/windowed_linear_chirp_generator.sv =====
// Top level of the windowed linear chirp generator.
// Uses wlcg_pkg and wlcg_sine_rom.
//
// Usage:
//   Each transaction on the req_ channel produces exactly one transaction on the
//   rsp_ channel. req_restart = 1 starts a new burst at sample zero; 0 advances by
//   one sample. After the last sample of the burst every transaction returns a zero
//   sample with rsp_idle = 1 until the next restart.
//   Registers are written through the csr_ APB port (byte address 4*index) while
//   no transaction is in flight; they take effect with the next request.
//   A result passes through three registered stages after its request is accepted
//   (ROM read, window multiply, rounding). Throughput: one transaction per cycle while
//   rsp_ready is high; the three pipeline registers fill independently, so requests keep
//   flowing while a result waits, and the pipeline holds when rsp_ready stays low and all
//   stages are full.
//   Reset (synchronous, active high): registers return to their defaults, the
//   pipeline empties and the generator is idle until a restart.
module windowed_linear_chirp_generator
   import wlcg_pkg::*;
#(
   parameter int PHASE_BITS      = PhaseBitsDef,
   parameter int TABLE_ADDR_BITS = TableAddrBitsDef,
   parameter int SAMPLE_BITS     = SampleBitsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_chirp_end,
   output logic                          rsp_burst_end,
   output logic                          rsp_idle,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CfgAddrBits-1:0]        csr_paddr,
   input  logic [CfgDataBits-1:0]        csr_pwdata,
   output logic [CfgDataBits-1:0]        csr_prdata,
   output logic                          csr_pready
);

   localparam int PB      = PHASE_BITS;
   localparam int AB      = TABLE_ADDR_BITS;
   localparam int SB      = SAMPLE_BITS;
   localparam int MagBits = SB - 1;
   localparam int ProdBits = 2 * MagBits;

   // ---------------- configuration registers ----------------
   logic [31:0]        first_step_ff;
   logic signed [31:0] step_growth_ff;
   logic [31:0]        window_step_ff;
   logic [15:0]        chirp_length_ff;
   logic [15:0]        chirp_repeats_ff;
   logic               window_on_ff;
   logic               output_sine_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[CfgAddrBits-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_step_ff    <= '0;
         step_growth_ff   <= '0;
         window_step_ff   <= '0;
         chirp_length_ff  <= ChirpLengthRst;
         chirp_repeats_ff <= ChirpRepeatsRst;
         window_on_ff     <= WindowOnRst;
         output_sine_ff   <= OutputSineRst;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FIRST_STEP:    first_step_ff    <= csr_pwdata;
            REG_STEP_GROWTH:   step_growth_ff   <= csr_pwdata;
            REG_WINDOW_STEP:   window_step_ff   <= csr_pwdata;
            REG_CHIRP_LENGTH:  chirp_length_ff  <= csr_pwdata[15:0];
            REG_CHIRP_REPEATS: chirp_repeats_ff <= csr_pwdata[15:0];
            REG_WINDOW_ON:     window_on_ff     <= csr_pwdata[0];
            REG_OUTPUT_SINE:   output_sine_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FIRST_STEP:    csr_prdata = first_step_ff;
         REG_STEP_GROWTH:   csr_prdata = step_growth_ff;
         REG_WINDOW_STEP:   csr_prdata = window_step_ff;
         REG_CHIRP_LENGTH:  csr_prdata = {16'd0, chirp_length_ff};
         REG_CHIRP_REPEATS: csr_prdata = {16'd0, chirp_repeats_ff};
         REG_WINDOW_ON:     csr_prdata = {31'd0, window_on_ff};
         REG_OUTPUT_SINE:   csr_prdata = {31'd0, output_sine_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load1, load2, load3;
   logic accept;

   assign load3  = !rsp_valid_ff || rsp_ready;
   assign load2  = !s2_valid_ff || load3;
   assign load1  = !s1_valid_ff || load2;
   assign req_ready = load1;
   assign accept = req_valid && load1;

   assign s1_valid_in  = load1 ? accept : s1_valid_ff;
   assign s2_valid_in  = load2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = load3 ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- sequencer state ----------------
   logic [15:0]   sample_index_ff, sample_index_in;
   logic [15:0]   chirp_count_ff, chirp_count_in;
   logic [PB-1:0] phase_acc_ff, phase_acc_in;
   logic [PB-1:0] phase_step_ff, phase_step_in;
   logic [PB-1:0] window_phase_ff, window_phase_in;
   logic          finished_ff, finished_in;

   logic [15:0]   idx_cur;
   logic [15:0]   cnt_cur;
   logic [PB-1:0] acc_cur;
   logic [PB-1:0] step_cur;
   logic [PB-1:0] wph_cur;
   logic          fin_cur;
   logic          chirp_end;
   logic          burst_end;
   logic [PB-1:0] first_step_ext;
   logic [PB-1:0] growth_ext;
   logic [PB-1:0] window_step_ext;
   flags_type     flags0;

   assign first_step_ext  = PB'(first_step_ff);
   assign growth_ext      = PB'(step_growth_ff);
   assign window_step_ext = PB'(window_step_ff);

   always_comb begin
      idx_cur  = sample_index_ff;
      cnt_cur  = chirp_count_ff;
      acc_cur  = phase_acc_ff;
      step_cur = phase_step_ff;
      wph_cur  = window_phase_ff;
      fin_cur  = finished_ff;
      if (req_restart) begin
         idx_cur  = '0;
         cnt_cur  = '0;
         acc_cur  = '0;
         step_cur = first_step_ext;
         wph_cur  = '0;
         fin_cur  = 1'b0;
      end

      chirp_end = !fin_cur && (idx_cur == chirp_length_ff - 16'd1);
      burst_end = chirp_end && (cnt_cur == chirp_repeats_ff - 16'd1);

      sample_index_in = idx_cur;
      chirp_count_in  = cnt_cur;
      phase_acc_in    = acc_cur;
      phase_step_in   = step_cur;
      window_phase_in = wph_cur;
      finished_in     = fin_cur;
      if (!fin_cur) begin
         if (chirp_end) begin
            sample_index_in = '0;
            chirp_count_in  = cnt_cur + 16'd1;
            finished_in     = burst_end;
            phase_acc_in    = '0;
            phase_step_in   = first_step_ext;
            window_phase_in = '0;
         end else begin
            sample_index_in = idx_cur + 16'd1;
            phase_acc_in    = acc_cur + step_cur;
            phase_step_in   = step_cur + growth_ext;
            window_phase_in = wph_cur + window_step_ext;
         end
      end

      flags0.chirp_end = chirp_end;
      flags0.burst_end = burst_end;
      flags0.idle      = fin_cur;
      flags0.window_on = window_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         chirp_count_ff  <= '0;
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         window_phase_ff <= '0;
         finished_ff     <= 1'b1;
      end else if (accept) begin
         sample_index_ff <= sample_index_in;
         chirp_count_ff  <= chirp_count_in;
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         window_phase_ff <= window_phase_in;
         finished_ff     <= finished_in;
      end
   end

   // ---------------- table addressing ----------------
   logic [AB+1:0] wave_top;
   logic [AB+1:0] win_top;
   logic [1:0]    wave_quad;
   logic [1:0]    win_quad;
   logic [AB:0]   wave_addr;
   logic [AB:0]   win_addr;

   assign wave_top  = acc_cur[PB-1 -: AB+2];
   assign win_top   = wph_cur[PB-1 -: AB+2];
   // cosine is sine a quarter turn ahead
   assign wave_quad = output_sine_ff ? wave_top[AB+1:AB] : wave_top[AB+1:AB] + 2'd1;
   assign win_quad  = win_top[AB+1:AB] + 2'd1;
   assign wave_addr = wave_quad[0] ? {1'b1, {AB{1'b0}}} - {1'b0, wave_top[AB-1:0]}
                                   : {1'b0, wave_top[AB-1:0]};
   assign win_addr  = win_quad[0] ? {1'b1, {AB{1'b0}}} - {1'b0, win_top[AB-1:0]}
                                  : {1'b0, win_top[AB-1:0]};

   // ---------------- stage 1: table read ----------------
   logic [MagBits-1:0] wave_mag;
   logic [MagBits-1:0] win_cos_mag;
   logic               s1_wave_neg_ff;
   logic               s1_win_neg_ff;
   flags_type          s1_flags_ff;

   wlcg_sine_rom #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_rom (
      .clock    (clock),
      .rd_en    (load1),
      .rd_addr_a(wave_addr),
      .rd_addr_b(win_addr),
      .rd_data_a(wave_mag),
      .rd_data_b(win_cos_mag)
   );

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_wave_neg_ff <= wave_quad[1];
         s1_win_neg_ff  <= win_quad[1];
         s1_flags_ff    <= flags0;
      end
   end

   // ---------------- stage 2: window gain and multiply ----------------
   logic [SB-1:0]       win_sum;
   logic [MagBits-1:0]  win_gain;
   logic [ProdBits-1:0] s2_prod_ff;
   logic [MagBits-1:0]  s2_wave_mag_ff;
   logic                s2_wave_neg_ff;
   flags_type           s2_flags_ff;

   // (full scale + 1 - cos) / 2
   assign win_sum  = s1_win_neg_ff ? {1'b1, {MagBits{1'b0}}} + {1'b0, win_cos_mag}
                                   : {1'b1, {MagBits{1'b0}}} - {1'b0, win_cos_mag};
   assign win_gain = win_sum[SB-1:1];

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_prod_ff     <= wave_mag * win_gain;
         s2_wave_mag_ff <= wave_mag;
         s2_wave_neg_ff <= s1_wave_neg_ff;
         s2_flags_ff    <= s1_flags_ff;
      end
   end

   // ---------------- stage 3: rounding and sign ----------------
   logic [ProdBits:0]    prod_rnd;
   logic [MagBits-1:0]   out_mag;
   logic [SB-1:0]        out_sample;
   logic signed [SB-1:0] rsp_sample_ff;
   flags_type            rsp_flags_ff;

   assign prod_rnd = {1'b0, s2_prod_ff} + (ProdBits + 1)'(1 << (SB - 2));
   assign out_mag  = s2_flags_ff.window_on ? prod_rnd[ProdBits-1:MagBits] : s2_wave_mag_ff;

   always_comb begin
      if (s2_flags_ff.idle) begin
         out_sample = '0;
      end else if (s2_wave_neg_ff) begin
         out_sample = '0 - {1'b0, out_mag};
      end else begin
         out_sample = {1'b0, out_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         rsp_sample_ff <= out_sample;
         rsp_flags_ff  <= s2_flags_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_chirp_end = rsp_flags_ff.chirp_end;
   assign rsp_burst_end = rsp_flags_ff.burst_end;
   assign rsp_idle      = rsp_flags_ff.idle;

endmodule

// ===== rtl/wlcg_sine_rom.sv =====
// Quarter-wave sine ROM with two registered read ports.
// Contents come from wlcg_pkg::sine_entry at elaboration.
module wlcg_sine_rom
   import wlcg_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = TableAddrBitsDef,
   parameter int SAMPLE_BITS     = SampleBitsDef
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [TABLE_ADDR_BITS:0]   rd_addr_a,
   input  logic [TABLE_ADDR_BITS:0]   rd_addr_b,
   output logic [SAMPLE_BITS-2:0]     rd_data_a,
   output logic [SAMPLE_BITS-2:0]     rd_data_b
);

   localparam int Depth   = (1 << TABLE_ADDR_BITS) + 1;
   localparam int MagBits = SAMPLE_BITS - 1;

   logic [MagBits-1:0] rom_table [Depth];
   logic [MagBits-1:0] data_a_ff;
   logic [MagBits-1:0] data_b_ff;

   for (genvar k = 0; k < Depth; k++) begin : g_entry
      localparam logic [MagBits-1:0] Entry =
         MagBits'(sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
      assign rom_table[k] = Entry;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= rom_table[rd_addr_a];
         data_b_ff <= rom_table[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// ===== tb/sv/windowed_linear_chirp_generator_tb.sv =====
// Testbench for the windowed linear chirp generator: a cycle-free predictor checks every
// rsp_ transaction, with directed bursts followed by random bursts under random pacing.
// Depends on wlcg_pkg and windowed_linear_chirp_generator.
module windowed_linear_chirp_generator_tb;
   import wlcg_pkg::*;

   localparam int          Amp         = 32767;
   localparam int          QuarterSize = 1024;
   localparam logic [31:0] QuarterTurn = 32'h4000_0000;
   localparam int          MaxTicks    = 60;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               chirp_end;
      logic               burst_end;
      logic               idle;
   } chirp_sample_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_restart;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [15:0]     rsp_sample;
   logic                   rsp_chirp_end;
   logic                   rsp_burst_end;
   logic                   rsp_idle;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CfgAddrBits-1:0] csr_paddr;
   logic [CfgDataBits-1:0] csr_pwdata;
   logic [CfgDataBits-1:0] csr_prdata;
   logic                   csr_pready;

   int unsigned      quarter_wave [0:QuarterSize];
   chirp_sample_type pending_samples [$];
   int               mismatch_count = 0;
   int               sent_count = 0;
   bit               pacing_on = 1'b1;
   int               stall_left = 0;

   // register shadow
   logic [31:0] first_step_q;
   logic [31:0] step_growth_q;
   logic [31:0] window_step_q;
   logic [15:0] chirp_length_q;
   logic [15:0] chirp_repeats_q;
   logic        window_on_q;
   logic        output_sine_q;

   // generator state
   logic [15:0] sample_idx;
   logic [15:0] chirp_idx;
   logic [31:0] phase;
   logic [31:0] phase_inc;
   logic [31:0] window_phase;
   bit          burst_done;

   windowed_linear_chirp_generator i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .rsp_chirp_end (rsp_chirp_end),
      .rsp_burst_end (rsp_burst_end),
      .rsp_idle      (rsp_idle),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

   // quarter-wave sine, truncated Taylor series in Q30, rounded and clamped
   function automatic void build_quarter_wave();
      longint unsigned x;
      longint unsigned acc;
      longint unsigned term;
      longint unsigned v;
      int              k;
      int              n;
      for (k = 0; k <= QuarterSize; k++) begin
         x    = (PiHalfQ30 * longint'(k)) >> 10;
         acc  = x;
         term = x;
         for (n = 1; n <= 10; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         v = (longint'(Amp) * acc + (64'd1 << 29)) >> 30;
         if (v > Amp) begin
            v = Amp;
         end
         quarter_wave[k] = int'(v);
      end
   endfunction

   function automatic int wave_at(logic [31:0] ph);
      int         mag;
      logic [9:0] k;
      k   = ph[29:20];
      mag = ph[30] ? int'(quarter_wave[QuarterSize - int'(k)]) : int'(quarter_wave[k]);
      return ph[31] ? -mag : mag;
   endfunction

   function automatic void reset_model();
      first_step_q    = '0;
      step_growth_q   = '0;
      window_step_q   = '0;
      chirp_length_q  = ChirpLengthRst;
      chirp_repeats_q = ChirpRepeatsRst;
      window_on_q     = WindowOnRst;
      output_sine_q   = OutputSineRst;
      sample_idx      = '0;
      chirp_idx       = '0;
      phase           = '0;
      phase_inc       = '0;
      window_phase    = '0;
      burst_done      = 1'b1;
   endfunction

   function automatic chirp_sample_type predict_chirp_sample(logic restart);
      chirp_sample_type s;
      int               wave;
      int               win;
      int               r;
      longint           mag;
      logic [15:0]      last_sample;
      logic [15:0]      last_chirp;
      s = '0;
      if (restart) begin
         sample_idx   = '0;
         chirp_idx    = '0;
         burst_done   = 1'b0;
         phase        = '0;
         phase_inc    = first_step_q;
         window_phase = '0;
      end
      if (burst_done) begin
         s.idle = 1'b1;
         return s;
      end
      wave = output_sine_q ? wave_at(phase) : wave_at(phase + QuarterTurn);
      if (window_on_q) begin
         win      = (Amp - wave_at(window_phase + QuarterTurn) + 1) / 2;
         mag      = longint'(wave < 0 ? -wave : wave) * win;
         r        = int'((mag + 16384) >>> 15);
         s.sample = 16'(wave < 0 ? -r : r);
      end else begin
         s.sample = 16'(wave);
      end
      last_sample = chirp_length_q - 16'd1;
      last_chirp  = chirp_repeats_q - 16'd1;
      s.chirp_end = (sample_idx == last_sample);
      s.burst_end = s.chirp_end && (chirp_idx == last_chirp);
      if (s.chirp_end) begin
         sample_idx   = '0;
         chirp_idx    = chirp_idx + 16'd1;
         burst_done   = s.burst_end;
         phase        = '0;
         phase_inc    = first_step_q;
         window_phase = '0;
      end else begin
         sample_idx   = sample_idx + 16'd1;
         phase        = phase + phase_inc;
         phase_inc    = phase_inc + step_growth_q;
         window_phase = window_phase + window_step_q;
      end
      return s;
   endfunction

   task automatic send_tick(logic restart);
      int               gap;
      chirp_sample_type expected;
      if (pacing_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      expected        = predict_chirp_sample(restart);
      pending_samples = {pending_samples, expected};
      sent_count++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FIRST_STEP: begin
            first_step_q = value;
         end
         REG_STEP_GROWTH: begin
            step_growth_q = value;
         end
         REG_WINDOW_STEP: begin
            window_step_q = value;
         end
         REG_CHIRP_LENGTH: begin
            chirp_length_q = value[15:0];
         end
         REG_CHIRP_REPEATS: begin
            chirp_repeats_q = value[15:0];
         end
         REG_WINDOW_ON: begin
            window_on_q = value[0];
         end
         REG_OUTPUT_SINE: begin
            output_sine_q = value[0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic write_burst_shape(logic [15:0] length, logic [15:0] repeats);
      write_csr(REG_CHIRP_LENGTH, 32'(length));
      write_csr(REG_CHIRP_REPEATS, 32'(repeats));
   endtask

   task automatic test_idle_after_reset();
      send_tick(1'b0);
      send_tick(1'b0);
   endtask

   task automatic test_default_burst();
      send_tick(1'b1);
      send_tick(1'b0);
      wait_for_drain();
   endtask

   task automatic test_field_extremes();
      int i;
      write_csr(REG_FIRST_STEP, 32'hFFFF_FFFF);
      write_csr(REG_STEP_GROWTH, 32'h8000_0000);
      write_csr(REG_WINDOW_STEP, 32'hFFFF_FFFF);
      write_burst_shape(16'd2, 16'd1);
      write_csr(REG_WINDOW_ON, 32'd0);
      write_csr(REG_OUTPUT_SINE, 32'd1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_for_drain();
      write_csr(REG_FIRST_STEP, 32'd0);
      write_csr(REG_STEP_GROWTH, 32'h7FFF_FFFF);
      write_csr(REG_WINDOW_STEP, 32'h8000_0000);
      write_burst_shape(16'd3, 16'd2);
      write_csr(REG_WINDOW_ON, 32'd1);
      write_csr(REG_OUTPUT_SINE, 32'd0);
      send_tick(1'b1);
      for (i = 0; i < 6; i++) begin
         send_tick(1'b0);
      end
      wait_for_drain();
   endtask

   task automatic test_single_sample_chirps();
      write_csr(REG_FIRST_STEP, 32'h1234_5678);
      write_burst_shape(16'd1, 16'd3);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_for_drain();
   endtask

   task automatic test_longest_counts();
      write_burst_shape(16'd0, 16'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_for_drain();
      write_burst_shape(16'hFFFF, 16'hFFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_for_drain();
   endtask

   // shorten the chirp while a burst is running
   task automatic test_config_mid_burst();
      write_burst_shape(16'd8, 16'd1);
      write_csr(REG_WINDOW_STEP, 32'h2000_0000);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_for_drain();
      write_csr(REG_CHIRP_LENGTH, 32'd5);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_for_drain();
   endtask

   task automatic test_random_bursts();
      logic [15:0] length;
      logic [15:0] repeats;
      logic [31:0] wstep;
      int          ticks;
      int          span;
      int          i;
      while (sent_count < 1100) begin
         wait_for_drain();
         pacing_on = (sent_count < 950) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 15))
            0: begin
               length = 16'($urandom_range(0, 1));
            end
            1: begin
               length = 16'($urandom_range(25, 65535));
            end
            default: begin
               length = 16'($urandom_range(2, 24));
            end
         endcase
         repeats = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
         if (length > 16'd1 && $urandom_range(0, 2) != 0) begin
            wstep = 32'((64'd1 << 32) / (64'(length) - 64'd1));
         end else begin
            wstep = $urandom;
         end
         write_csr(REG_FIRST_STEP, $urandom);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(REG_STEP_GROWTH, $urandom);
         end else begin
            write_csr(REG_STEP_GROWTH, 32'(int'($urandom_range(0, 20000)) - 10000));
         end
         write_csr(REG_WINDOW_STEP, wstep);
         write_csr(REG_CHIRP_LENGTH, {16'($urandom), length});
         write_csr(REG_CHIRP_REPEATS, {16'($urandom), repeats});
         write_csr(REG_WINDOW_ON, $urandom);
         write_csr(REG_OUTPUT_SINE, $urandom);
         span  = (length == 16'd0) ? 65536 : int'(length);
         ticks = (repeats == 16'd0) ? MaxTicks : span * int'(repeats);
         ticks = ticks + $urandom_range(0, 3);
         if (ticks > MaxTicks) begin
            ticks = MaxTicks;
         end
         send_tick(1'b1);
         for (i = 1; i < ticks; i++) begin
            send_tick($urandom_range(0, 24) == 0);
         end
      end
      pacing_on = 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (pacing_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_samples
      chirp_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected transaction: sample %0d", rsp_sample);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
               mismatch_count++;
            end
            if (rsp_chirp_end !== want.chirp_end) begin
               $error("chirp_end: expected %0b, got %0b", want.chirp_end, rsp_chirp_end);
               mismatch_count++;
            end
            if (rsp_burst_end !== want.burst_end) begin
               $error("burst_end: expected %0b, got %0b", want.burst_end, rsp_burst_end);
               mismatch_count++;
            end
            if (rsp_idle !== want.idle) begin
               $error("idle: expected %0b, got %0b", want.idle, rsp_idle);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      build_quarter_wave();
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_after_reset();
      test_default_burst();
      test_field_extremes();
      test_single_sample_chirps();
      test_longest_counts();
      test_config_mid_burst();
      test_random_bursts();
      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
